// ===== rtl/fcl_pkg.sv =====
// Shared types and constants of the fully connected layer forward block.
// Used by the top level and fcl_mac; no dependencies of its own.
package fcl_pkg;

   localparam int MAX_INPUTS   = 1024;
   localparam int MAX_OUTPUTS  = 64;

   localparam int IN_IDX_W     = 10;
   localparam int OUT_IDX_W    = 6;
   localparam int W_ADDR_W     = IN_IDX_W + OUT_IDX_W;
   localparam int WEIGHT_DEPTH = MAX_INPUTS * MAX_OUTPUTS;

   localparam int SMALL_W      = 16;
   localparam int PROD_W       = 2 * SMALL_W;
   localparam int BIAS_W       = 32;
   localparam int ACC_W        = 40;

   localparam int IN_CNT_W     = 11;
   localparam int OUT_CNT_W    = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_COUNT = 2'd1;

   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_ACT    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   typedef struct packed {
      logic                 vld;
      logic [OUT_IDX_W-1:0] idx;
   } mac_ctl_type;

endpackage

// ===== rtl/fully_connected_layer_forward.sv =====
// Fully connected layer forward pass y = W.x + b, top level with sequencer.
// Depends on fcl_pkg, fcl_ram and fcl_mac.
//
// req_* carries one transaction: a weight write, a bias write or one
// activation element. An activation inside input_count runs output_count
// multiply-accumulates through one shared MAC unit, one neuron per cycle.
// req_stall stays high until the sequencer is back in idle.
// An activation marked last then reads accumulator and bias of each neuron
// in turn and places one rsp_* transaction per neuron in the output
// register; each neuron passes through S_EMIT_RD and then S_EMIT_LD.
// rsp_last_result marks the final neuron. rsp_stall holds the output
// register and the sequencer; a new request is taken once the last result
// sits in the output register. Accumulators are cleared by their valid
// bits after the final result, so no clearing pass is needed.
// csr_* writes input_count and output_count, used clamped to their ranges.
// Synchronous reset clears control state and sets both counts to one;
// weight and bias stores are undefined until written.
module fully_connected_layer_forward import fcl_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [IN_IDX_W-1:0]         req_in_index,
   input  logic [OUT_IDX_W-1:0]        req_out_index,
   input  logic signed [SMALL_W-1:0]   req_small_value,
   input  logic signed [BIAS_W-1:0]    req_bias_value,
   input  logic                        req_last_input,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [OUT_IDX_W-1:0]        rsp_neuron_index,
   output logic signed [BIAS_W-1:0]    rsp_neuron_value,
   output logic                        rsp_last_result
);

   localparam logic signed [ACC_W:0] RES_HI = (ACC_W+1)'(64'sd2147483647);
   localparam logic signed [ACC_W:0] RES_LO = -(ACC_W+1)'(64'sd2147483648);

   state_type                 state_ff, state_in;
   logic [OUT_IDX_W-1:0]      cnt_ff, cnt_in;
   logic [IN_CNT_W-1:0]       in_count_ff;
   logic [OUT_CNT_W-1:0]      out_count_ff;
   logic [IN_IDX_W-1:0]       ii_ff;
   logic signed [SMALL_W-1:0] act_ff;
   logic                      last_ff;
   logic [MAX_OUTPUTS-1:0]    acc_vld_ff;
   mac_ctl_type               s1_ff, s1_in;
   logic                      s1_avld_ff;
   logic                      rsp_valid_ff;
   logic [OUT_IDX_W-1:0]      rsp_idx_ff;
   logic signed [BIAS_W-1:0]  rsp_value_ff;
   logic                      rsp_last_ff;

   logic                      req_take;
   logic                      rsp_load;
   logic                      acc_clear;
   logic [IN_CNT_W-1:0]       nin;
   logic [OUT_CNT_W-1:0]      nout;
   logic [OUT_IDX_W-1:0]      last_idx;
   logic                      in_range;

   logic signed [SMALL_W-1:0] w_rd;
   logic signed [BIAS_W-1:0]  b_rd;
   logic signed [ACC_W-1:0]   a_rd;
   logic signed [ACC_W-1:0]   a_cur;
   mac_ctl_type               mac_wr;
   logic signed [ACC_W-1:0]   mac_sum;
   logic signed [ACC_W:0]     res_wide;
   logic signed [BIAS_W-1:0]  res_sat;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      if (in_count_ff == '0) begin
         nin = IN_CNT_W'(1);
      end else if (in_count_ff > IN_CNT_W'(MAX_INPUTS)) begin
         nin = IN_CNT_W'(MAX_INPUTS);
      end else begin
         nin = in_count_ff;
      end
      if (out_count_ff == '0) begin
         nout = OUT_CNT_W'(1);
      end else if (out_count_ff > OUT_CNT_W'(MAX_OUTPUTS)) begin
         nout = OUT_CNT_W'(MAX_OUTPUTS);
      end else begin
         nout = out_count_ff;
      end
   end

   assign last_idx = OUT_IDX_W'(nout - OUT_CNT_W'(1));
   assign in_range = {1'b0, req_in_index} < nin;

   fcl_ram #(.WIDTH(SMALL_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (req_take && (req_cmd == CMD_WEIGHT)),
      .wr_addr ({req_in_index, req_out_index}),
      .wr_data (req_small_value),
      .rd_addr ({ii_ff, cnt_ff}),
      .rd_data (w_rd)
   );

   fcl_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (req_take && (req_cmd == CMD_BIAS)),
      .wr_addr (req_out_index),
      .wr_data (req_bias_value),
      .rd_addr (cnt_ff),
      .rd_data (b_rd)
   );

   fcl_ram #(.WIDTH(ACC_W), .DEPTH(MAX_OUTPUTS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (mac_wr.vld),
      .wr_addr (mac_wr.idx),
      .wr_data (mac_sum),
      .rd_addr (cnt_ff),
      .rd_data (a_rd)
   );

   assign a_cur = s1_avld_ff ? a_rd : '0;

   assign s1_in.vld = (state_ff == S_MAC);
   assign s1_in.idx = cnt_ff;

   fcl_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (s1_ff),
      .weight  (w_rd),
      .act     (act_ff),
      .acc     (a_cur),
      .out_ctl (mac_wr),
      .sum     (mac_sum)
   );

   always_comb begin
      res_wide = {a_cur[ACC_W-1], a_cur} + (ACC_W+1)'(b_rd);
      if (res_wide > RES_HI) begin
         res_sat = RES_HI[BIAS_W-1:0];
      end else if (res_wide < RES_LO) begin
         res_sat = RES_LO[BIAS_W-1:0];
      end else begin
         res_sat = res_wide[BIAS_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rsp_load  = 1'b0;
      acc_clear = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take && (req_cmd == CMD_ACT)) begin
               cnt_in = '0;
               if (in_range) begin
                  state_in = S_MAC;
               end else if (req_last_input) begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_MAC: begin
            if (cnt_ff == last_idx) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + OUT_IDX_W'(1);
            end
         end
         S_DRAIN: begin
            if (!s1_ff.vld && !mac_wr.vld) begin
               cnt_in   = '0;
               state_in = last_ff ? S_EMIT_RD : S_IDLE;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               if (cnt_ff == last_idx) begin
                  acc_clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + OUT_IDX_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         acc_vld_ff   <= '0;
         s1_ff.vld    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         in_count_ff  <= IN_CNT_W'(1);
         out_count_ff <= OUT_CNT_W'(1);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_ff.vld    <= s1_in.vld;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         if (acc_clear) begin
            acc_vld_ff <= '0;
         end else if (mac_wr.vld) begin
            acc_vld_ff[mac_wr.idx] <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INPUT_COUNT:  in_count_ff  <= csr_wr_data[IN_CNT_W-1:0];
               CSR_OUTPUT_COUNT: out_count_ff <= csr_wr_data[OUT_CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      s1_ff.idx <= s1_in.idx;
   end

   always_ff @(posedge clock) begin
      s1_avld_ff <= acc_vld_ff[cnt_ff];
      if (req_take) begin
         ii_ff   <= req_in_index;
         act_ff  <= req_small_value;
         last_ff <= req_last_input;
      end
      if (rsp_load) begin
         rsp_idx_ff   <= cnt_ff;
         rsp_value_ff <= res_sat;
         rsp_last_ff  <= (cnt_ff == last_idx);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_neuron_index = rsp_idx_ff;
   assign rsp_neuron_value = rsp_value_ff;
   assign rsp_last_result  = rsp_last_ff;

   a_no_mac_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_RD || state_ff == S_EMIT_LD || state_ff == S_IDLE) |-> !mac_wr.vld)
      else $error("accumulator write outside the accumulate phase");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && cnt_ff == last_idx) |=> (acc_vld_ff == '0))
      else $error("accumulators not cleared after final result");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC || state_ff == S_EMIT_LD) |-> (cnt_ff <= last_idx))
      else $error("neuron counter beyond neurons in use");

endmodule

// ===== rtl/fcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module fcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fcl_mac.sv =====
// Shared multiply-accumulate unit: registered Q16.16 product of Q8.8 operands, then 40-bit saturating add.
// Depends on fcl_pkg.
module fcl_mac import fcl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctl_type              in_ctl,
   input  logic signed [SMALL_W-1:0] weight,
   input  logic signed [SMALL_W-1:0] act,
   input  logic signed [ACC_W-1:0]  acc,
   output mac_ctl_type              out_ctl,
   output logic signed [ACC_W-1:0]  sum
);

   localparam logic signed [ACC_W:0] ACC_HI = {2'b00, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W:0] ACC_LO = {2'b11, {(ACC_W-1){1'b0}}};

   mac_ctl_type              ctl_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W:0]    wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld <= 1'b0;
      end else begin
         ctl_ff.vld <= in_ctl.vld;
      end
      ctl_ff.idx <= in_ctl.idx;
      prod_ff    <= weight * act;
      acc_ff     <= acc;
   end

   always_comb begin
      wide = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(prod_ff);
      if (wide > ACC_HI) begin
         sum = ACC_HI[ACC_W-1:0];
      end else if (wide < ACC_LO) begin
         sum = ACC_LO[ACC_W-1:0];
      end else begin
         sum = wide[ACC_W-1:0];
      end
   end

   assign out_ctl = ctl_ff;

endmodule

// ===== verif/fully_connected_layer_forward_test.sv =====
// Self-checking bench for fully_connected_layer_forward: a stimulus table,
// then random layer vectors under several input/output counts, checked by a
// fixed-point predictor of y = W.x + b. Depends on fcl_pkg and the RTL only.
module fully_connected_layer_forward_test import fcl_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]           CMD_UNUSED      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;
   localparam longint ACC_HI        = 64'sd549755813887;
   localparam longint ACC_LO        = -ACC_HI - 1;
   localparam longint OUT_HI        = 64'sd2147483647;
   localparam longint OUT_LO        = -OUT_HI - 1;
   localparam int     DRAIN_CYCLES  = 100;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     PHASES        = 4;

   typedef struct {
      logic [1:0]                cmd;
      logic [IN_IDX_W-1:0]       in_index;
      logic [OUT_IDX_W-1:0]      out_index;
      logic signed [SMALL_W-1:0] small_value;
      logic signed [BIAS_W-1:0]  bias_value;
      logic                      last_input;
      bit                        has_exp;
      logic signed [BIAS_W-1:0]  exp_value;
   } layer_txn_type;

   typedef struct {
      logic [OUT_IDX_W-1:0]      index;
      logic signed [BIAS_W-1:0]  value;
      logic                      last;
   } neuron_out_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_cmd;
   logic [IN_IDX_W-1:0]       req_in_index;
   logic [OUT_IDX_W-1:0]      req_out_index;
   logic signed [SMALL_W-1:0] req_small_value;
   logic signed [BIAS_W-1:0]  req_bias_value;
   logic                      req_last_input;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [OUT_IDX_W-1:0]      rsp_neuron_index;
   logic signed [BIAS_W-1:0]  rsp_neuron_value;
   logic                      rsp_last_result;

   fully_connected_layer_forward dut (.*);

   // layer image kept by the bench
   logic [IN_CNT_W-1:0]       in_count_reg  = IN_CNT_W'(1);
   logic [OUT_CNT_W-1:0]      out_count_reg = OUT_CNT_W'(1);
   logic signed [SMALL_W-1:0] weight_image [WEIGHT_DEPTH];
   bit                        weight_known [WEIGHT_DEPTH];
   logic signed [BIAS_W-1:0]  bias_image [MAX_OUTPUTS];
   bit                        bias_known [MAX_OUTPUTS];
   longint                    acc_image [MAX_OUTPUTS];
   neuron_out_type            expected_neurons [$];

   int  position_pool [$];
   bit  calm = 1'b0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  fault_count = 0;
   int  txn_count = 0;
   int  result_count = 0;
   int  csr_count = 0;

   logic [IN_CNT_W-1:0]  in_settings  [PHASES] = '{11'd1024, 11'd2047, 11'd0, 11'd3};
   logic [OUT_CNT_W-1:0] out_settings [PHASES] = '{7'd64, 7'd127, 7'd0, 7'd5};

   layer_txn_type directed_txns [21] = '{
      '{CMD_WEIGHT, 10'd0,    6'd0,  16'sh0100, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_BIAS,   10'd0,    6'd0,  16'sh0000, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'sh0100, 32'sh00000000, 1'b1, 1'b1, 32'sh00010000},
      '{CMD_WEIGHT, 10'd0,    6'd0,  16'sh8000, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_BIAS,   10'd0,    6'd0,  16'sh0000, 32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'sh8000, 32'sh00000000, 1'b1, 1'b1, 32'sh7FFFFFFF},
      '{CMD_BIAS,   10'd0,    6'd0,  16'sh0000, 32'sh80000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_WEIGHT, 10'd0,    6'd0,  16'sh7FFF, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'sh8000, 32'sh00000000, 1'b1, 1'b1, 32'sh80000000},
      '{CMD_ACT,    10'd1023, 6'd0,  16'sh7FFF, 32'sh00000000, 1'b1, 1'b1, 32'sh80000000},
      '{CMD_UNUSED, 10'd1023, 6'd63, 16'shFFFF, 32'shFFFFFFFF, 1'b1, 1'b0, 32'sh0},
      '{CMD_WEIGHT, 10'd1023, 6'd63, 16'sh5A5A, 32'shFFFFFFFF, 1'b1, 1'b0, 32'sh0},
      '{CMD_BIAS,   10'd1023, 6'd63, 16'shFFFF, 32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0},
      '{CMD_BIAS,   10'd0,    6'd0,  16'sh0000, 32'sh00000001, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'sh0200, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd512,  6'd0,  16'sh7FFF, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'shFFFF, 32'sh00000000, 1'b1, 1'b0, 32'sh0},
      '{CMD_WEIGHT, 10'd0,    6'd0,  16'sh0000, 32'sh00000000, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'sh1234, 32'sh00000000, 1'b1, 1'b1, 32'sh00000001},
      '{CMD_BIAS,   10'd0,    6'd0,  16'sh0000, 32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0},
      '{CMD_ACT,    10'd0,    6'd0,  16'sh7FFF, 32'sh00000000, 1'b1, 1'b1, 32'shFFFFFFFF}
   };

   always begin
      clock = 1'b0;
      #5ns;
      clock = 1'b1;
      #5ns;
   end

   function automatic int live_inputs();
      if (in_count_reg == 0) return 1;
      if (in_count_reg > MAX_INPUTS) return MAX_INPUTS;
      return int'(in_count_reg);
   endfunction

   function automatic int live_outputs();
      if (out_count_reg == 0) return 1;
      if (out_count_reg > MAX_OUTPUTS) return MAX_OUTPUTS;
      return int'(out_count_reg);
   endfunction

   function automatic longint saturate(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   task automatic advance_layer(input layer_txn_type t);
      int             n_out;
      int             n_in;
      int             n;
      longint         sum;
      neuron_out_type r;
      n_out = live_outputs();
      n_in  = live_inputs();
      case (t.cmd)
         CMD_WEIGHT: begin
            weight_image[{t.in_index, t.out_index}] = t.small_value;
            weight_known[{t.in_index, t.out_index}] = 1'b1;
         end
         CMD_BIAS: begin
            bias_image[t.out_index] = t.bias_value;
            bias_known[t.out_index] = 1'b1;
         end
         CMD_ACT: begin
            if (t.in_index < n_in) begin
               for (n = 0; n < n_out; n++) begin
                  sum = acc_image[n] + longint'(t.small_value)
                        * longint'(weight_image[t.in_index * MAX_OUTPUTS + n]);
                  acc_image[n] = saturate(sum, ACC_LO, ACC_HI);
               end
            end
            if (t.last_input) begin
               for (n = 0; n < n_out; n++) begin
                  sum     = saturate(acc_image[n] + longint'(bias_image[n]), OUT_LO, OUT_HI);
                  r.index = OUT_IDX_W'(n);
                  r.value = sum[BIAS_W-1:0];
                  r.last  = (n == n_out - 1);
                  expected_neurons.insert(expected_neurons.size(), r);
               end
               for (n = 0; n < MAX_OUTPUTS; n++) acc_image[n] = 0;
            end
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic signed [SMALL_W-1:0] pick_small();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return SMALL_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [BIAS_W-1:0] pick_bias();
      case ($urandom_range(0, 9))
         0: return 32'sh80000000;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh00000000;
         3: return BIAS_W'(int'($urandom_range(0, 65535)) - 32768);
         default: return BIAS_W'($urandom);
      endcase
   endfunction

   function automatic layer_txn_type random_txn(input logic [1:0] cmd);
      layer_txn_type t;
      t.cmd         = cmd;
      t.in_index    = IN_IDX_W'($urandom);
      t.out_index   = OUT_IDX_W'($urandom);
      t.small_value = pick_small();
      t.bias_value  = pick_bias();
      t.last_input  = 1'($urandom);
      t.has_exp     = 1'b0;
      t.exp_value   = '0;
      return t;
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   task automatic send_item(input layer_txn_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cmd         = t.cmd;
      req_in_index    = t.in_index;
      req_out_index   = t.out_index;
      req_small_value = t.small_value;
      req_bias_value  = t.bias_value;
      req_last_input  = t.last_input;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_layer(t);
      if (t.has_exp) expected_neurons[expected_neurons.size() - 1].value = t.exp_value;
      txn_count++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(posedge clock);
      if (idx == CSR_INPUT_COUNT) in_count_reg = data[IN_CNT_W-1:0];
      else if (idx == CSR_OUTPUT_COUNT) out_count_reg = data[OUT_CNT_W-1:0];
      csr_count++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic settle_block();
      req_valid = 1'b0;
      while (expected_neurons.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write any weight or bias the activation would read before it goes out
   task automatic drive_activation(input int ii, input logic signed [SMALL_W-1:0] value,
                                   input logic last);
      layer_txn_type t;
      int            n;
      if (ii < live_inputs()) begin
         for (n = 0; n < live_outputs(); n++) begin
            if (!weight_known[ii * MAX_OUTPUTS + n]) begin
               t           = random_txn(CMD_WEIGHT);
               t.in_index  = IN_IDX_W'(ii);
               t.out_index = OUT_IDX_W'(n);
               send_item(t);
            end
         end
      end
      if (last) begin
         for (n = 0; n < live_outputs(); n++) begin
            if (!bias_known[n]) begin
               t           = random_txn(CMD_BIAS);
               t.out_index = OUT_IDX_W'(n);
               send_item(t);
            end
         end
      end
      t             = random_txn(CMD_ACT);
      t.in_index    = IN_IDX_W'(ii);
      t.small_value = value;
      t.last_input  = last;
      send_item(t);
   endtask

   task automatic run_vector(input int len);
      int k;
      int ii;
      int roll;
      for (k = 0; k < len; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) send_item(random_txn(CMD_WEIGHT));
         else if (roll < 12) send_item(random_txn(CMD_BIAS));
         else if (roll < 15) send_item(random_txn(CMD_UNUSED));
         if (live_inputs() < MAX_INPUTS && $urandom_range(0, 9) == 0)
            ii = $urandom_range(live_inputs(), MAX_INPUTS - 1);
         else
            ii = position_pool[$urandom_range(0, position_pool.size() - 1)];
         drive_activation(ii, pick_small(), k == len - 1);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      neuron_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_neurons.size() == 0) begin
            log_fault($sformatf("unexpected result at %0t: idx %0d val %h last %b",
                                $time, rsp_neuron_index, rsp_neuron_value, rsp_last_result));
         end else begin
            want = expected_neurons.pop_front();
            if (rsp_neuron_index !== want.index || rsp_neuron_value !== want.value ||
                rsp_last_result !== want.last)
               log_fault($sformatf({"mismatch at %0t: expected idx %0d val %h last %b,",
                                    " got idx %0d val %h last %b"}, $time,
                                   want.index, want.value, want.last,
                                   rsp_neuron_index, rsp_neuron_value, rsp_last_result));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                     idle_cycles, expected_neurons.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int ph;
      int k;
      int len;
      int acts;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_cmd         = '0;
      req_in_index    = '0;
      req_out_index   = '0;
      req_small_value = '0;
      req_bias_value  = '0;
      req_last_input  = 1'b0;
      for (k = 0; k < MAX_OUTPUTS; k++) acc_image[k] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < $size(directed_txns); k++) send_item(directed_txns[k]);

      for (ph = 0; ph < PHASES; ph++) begin
         settle_block();
         calm = (ph % 3 == 2);
         write_csr(CSR_INPUT_COUNT, in_settings[ph]);
         write_csr(CSR_OUTPUT_COUNT, {4'($urandom), out_settings[ph]});
         if (ph == 2) begin
            write_csr(CSR_UNMAPPED_LO, CSR_DATA_W'($urandom));
            write_csr(CSR_UNMAPPED_HI, CSR_DATA_W'($urandom));
         end
         position_pool.delete();
         position_pool.insert(position_pool.size(), live_inputs() - 1);
         repeat ((live_outputs() >= 32) ? 0 : 1)
            position_pool.insert(position_pool.size(), $urandom_range(0, live_inputs() - 1));
         acts = 0;
         while (acts < 4) begin
            len = $urandom_range(1, 3);
            run_vector(len);
            acts += len;
         end
      end

      settle_block();
      $display("run covered %0d requests, %0d neuron results, %0d register writes",
               txn_count, result_count, csr_count);
      $display("counts swept to both ends and past them, with extreme weights, biases and inputs");
      if (expected_neurons.size() != 0)
         log_fault($sformatf("%0d expected results never arrived", expected_neurons.size()));
      if (fault_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d faults", fault_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
